FILE: rtl/bat_pkg.sv
// Shared types and constants for the adaptive threshold block.
// No dependencies; imported by bat_store, the top level and the testbench.
`default_nettype none

package bat_pkg;

    // Default frame limits for the top level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Field and store widths
    localparam int CFG_W    = 9;
    localparam int PIX_W    = 8;
    localparam int INTEG_W  = 24;
    localparam int ROWSUM_W = 16;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;

    // Window half size is width >> HALF_SHIFT
    localparam int HALF_SHIFT = 4;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Result codes
    localparam logic [PIX_W-1:0] PIX_DARK  = 8'd0;
    localparam logic [PIX_W-1:0] PIX_LIGHT = 8'd255;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    // Write strobes for the pixel and integral stores
    typedef struct packed {
        logic integ_wr;
        logic pix_wr;
    } mem_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bat_muladd.sv
// Shared multiply-add unit: q = a * b + c, registered.
// Depends on nothing but its parameters.
`default_nettype none

module bat_muladd
#(
    parameter int A_W = 16,
    parameter int B_W = 9,
    parameter int C_W = 8
)
(
    input  wire logic                   clk,
    input  wire logic [A_W-1:0]         a,
    input  wire logic [B_W-1:0]         b,
    input  wire logic [C_W-1:0]         c,
    output logic      [A_W+B_W:0]       q
);

    logic [A_W+B_W:0] q_reg;
    logic [A_W+B_W:0] q_next;

    always_comb
    begin
        q_next = (A_W+B_W+1)'(a) * (A_W+B_W+1)'(b) + (A_W+B_W+1)'(c);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: rtl/bat_store.sv
// Pixel store and integral image store, one shared address, registered reads.
// Depends on bat_pkg for widths and the write command struct.
`default_nettype none

module bat_store
    import bat_pkg::*;
#(
    parameter int ADDR_W = 16
)
(
    input  wire logic                clk,
    input  wire mem_cmd_t            cmd,
    input  wire logic [ADDR_W-1:0]   addr,
    input  wire logic [PIX_W-1:0]    pix_wdata,
    input  wire logic [INTEG_W-1:0]  integ_wdata,
    output logic      [PIX_W-1:0]    pix_rdata,
    output logic      [INTEG_W-1:0]  integ_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [PIX_W-1:0]   pix_mem   [DEPTH];
    logic [INTEG_W-1:0] integ_mem [DEPTH];
    logic [PIX_W-1:0]   pix_rd_reg;
    logic [INTEG_W-1:0] integ_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pix_wr)
        begin
            pix_mem[addr] <= pix_wdata;
        end
        pix_rd_reg <= pix_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.integ_wr)
        begin
            integ_mem[addr] <= integ_wdata;
        end
        integ_rd_reg <= integ_mem[addr];
    end

    assign pix_rdata   = pix_rd_reg;
    assign integ_rdata = integ_rd_reg;

endmodule

`default_nettype wire

FILE: rtl/bradley_adaptive_threshold_unit.sv
// Adaptive threshold over an integral image; sequencer, registers and APB port.
// Load item: busy through the above read and the integral write. Emit item: busy through the
// corner reads, pixel read, area, product, scale and compare; done is high in the first cycle
// with busy low. One shared multiply-add and one single-port integral store (four corner reads).
// Emit before the frame is loaded and ignored loads never leave idle. Receiver cannot stall: done lasts one cycle.
// Async active-low reset: idle, positions and row sum cleared, width and height 256.
`default_nettype none

module bradley_adaptive_threshold_unit
    import bat_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cmd,
    input  wire logic [PIX_W-1:0]     gray_pixel,
    output logic                      done,
    output logic      [PIX_W-1:0]     binary_out,
    output logic                      status,
    output logic                      last_pixel,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CRD_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int S_W     = DIM_W + 1;
    localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int MUL_A_W = 2 * CRD_W;
    localparam int MUL_B_W = (DIM_W > PIX_W) ? DIM_W : PIX_W;
    localparam int MUL_Q_W = MUL_A_W + MUL_B_W + 1;
    localparam int LHS_W   = MUL_Q_W + 4;
    localparam int RHS_W   = INTEG_W + 3;
    localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_L_UP    = 4'd1;
    localparam logic [3:0] ST_L_WR    = 4'd2;
    localparam logic [3:0] ST_E_A22   = 4'd3;
    localparam logic [3:0] ST_E_A21   = 4'd4;
    localparam logic [3:0] ST_E_A12   = 4'd5;
    localparam logic [3:0] ST_E_A11   = 4'd6;
    localparam logic [3:0] ST_E_PIX   = 4'd7;
    localparam logic [3:0] ST_E_AREA  = 4'd8;
    localparam logic [3:0] ST_E_PROD  = 4'd9;
    localparam logic [3:0] ST_E_SCALE = 4'd10;
    localparam logic [3:0] ST_E_CMP   = 4'd11;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;

    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic                cfg_wr;

    logic [CRD_W-1:0]    load_x_reg;
    logic [CRD_W-1:0]    load_y_reg;
    logic [CRD_W-1:0]    emit_x_reg;
    logic [CRD_W-1:0]    emit_y_reg;
    logic [ROWSUM_W-1:0] rowsum_reg;
    logic                frame_ready_reg;

    logic [PIX_W-1:0]    pix_reg;
    logic [CRD_W-1:0]    x1_reg;
    logic [CRD_W-1:0]    x2_reg;
    logic [CRD_W-1:0]    y1_reg;
    logic [CRD_W-1:0]    y2_reg;
    logic [INTEG_W-1:0]  acc_reg;
    logic [LHS_W-1:0]    lhs_reg;
    logic [RHS_W-1:0]    rhs_reg;

    logic                done_reg;
    logic [PIX_W-1:0]    binary_reg;
    logic                status_reg;
    logic                last_reg;

    logic [DIM_W-1:0]    eff_w;
    logic [DIM_W-1:0]    eff_h;
    logic [DIM_W-1:0]    half;
    logic [S_W-1:0]      ex;
    logic [S_W-1:0]      ey;
    logic [S_W-1:0]      ext_half;
    logic [S_W-1:0]      x2_sum;
    logic [S_W-1:0]      y2_sum;
    logic [CRD_W-1:0]    x1_next;
    logic [CRD_W-1:0]    x2_next;
    logic [CRD_W-1:0]    y1_next;
    logic [CRD_W-1:0]    y2_next;

    logic                accept;
    logic                load_row_end;
    logic                load_col_end;
    logic                emit_row_end;
    logic                emit_col_end;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [CRD_W-1:0]    mul_c;
    logic [MUL_Q_W-1:0]  mul_q;

    mem_cmd_t            mem_cmd;
    logic [INTEG_W-1:0]  integ_wdata;
    logic [INTEG_W-1:0]  integ_rd;
    logic [PIX_W-1:0]    pix_rd;

    // Clamp the frame size registers to the supported range
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = DIM_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = DIM_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = DIM_W'(height_reg);
        end
    end

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;

    assign load_col_end = (S_W'(load_x_reg) == S_W'(eff_w) - S_W'(1));
    assign load_row_end = (S_W'(load_y_reg) == S_W'(eff_h) - S_W'(1));
    assign emit_col_end = (S_W'(emit_x_reg) == S_W'(eff_w) - S_W'(1));
    assign emit_row_end = (S_W'(emit_y_reg) == S_W'(eff_h) - S_W'(1));

    // Window corners, clamped at the frame edges
    always_comb
    begin
        half     = eff_w >> HALF_SHIFT;
        ex       = S_W'(emit_x_reg);
        ey       = S_W'(emit_y_reg);
        ext_half = S_W'(half);
        x2_sum   = ex + ext_half;
        y2_sum   = ey + ext_half;

        x1_next = (ex >= ext_half) ? CRD_W'(ex - ext_half) : '0;
        y1_next = (ey >= ext_half) ? CRD_W'(ey - ext_half) : '0;
        x2_next = (x2_sum >= S_W'(eff_w)) ? CRD_W'(S_W'(eff_w) - S_W'(1)) : CRD_W'(x2_sum);
        y2_next = (y2_sum >= S_W'(eff_h)) ? CRD_W'(S_W'(eff_h) - S_W'(1)) : CRD_W'(y2_sum);
    end

    // Operand select for the shared multiply-add
    always_comb
    begin
        mul_a = '0;
        mul_b = MUL_B_W'(eff_w);
        mul_c = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = MUL_A_W'(load_y_reg - CRD_W'(1));
                mul_c = load_x_reg;
            end
            ST_L_UP:
            begin
                mul_a = MUL_A_W'(load_y_reg);
                mul_c = load_x_reg;
            end
            ST_E_A22:
            begin
                mul_a = MUL_A_W'(y2_reg);
                mul_c = x2_reg;
            end
            ST_E_A21:
            begin
                mul_a = MUL_A_W'(y1_reg);
                mul_c = x2_reg;
            end
            ST_E_A12:
            begin
                mul_a = MUL_A_W'(y2_reg);
                mul_c = x1_reg;
            end
            ST_E_A11:
            begin
                mul_a = MUL_A_W'(y1_reg);
                mul_c = x1_reg;
            end
            ST_E_PIX:
            begin
                mul_a = MUL_A_W'(emit_y_reg);
                mul_c = emit_x_reg;
            end
            ST_E_AREA:
            begin
                mul_a = MUL_A_W'(x2_reg - x1_reg);
                mul_b = MUL_B_W'(y2_reg - y1_reg);
            end
            ST_E_PROD:
            begin
                mul_a = mul_q[MUL_A_W-1:0];
                mul_b = MUL_B_W'(pix_rd);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    bat_muladd
    #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W),
        .C_W (CRD_W)
    )
    u_muladd
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .c   (mul_c),
        .q   (mul_q)
    );

    assign mem_cmd.integ_wr = (state_reg == ST_L_WR);
    assign mem_cmd.pix_wr   = (state_reg == ST_L_WR);

    // Top row has nothing above it
    assign integ_wdata = ((load_y_reg != '0) ? integ_rd : '0) + INTEG_W'(rowsum_reg);

    bat_store
    #(
        .ADDR_W (ADDR_W)
    )
    u_store
    (
        .clk         (clk),
        .cmd         (mem_cmd),
        .addr        (mul_q[ADDR_W-1:0]),
        .pix_wdata   (pix_reg),
        .integ_wdata (integ_wdata),
        .pix_rdata   (pix_rd),
        .integ_rdata (integ_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !cfg_wr)
                begin
                    if (!cmd && !frame_ready_reg)
                    begin
                        state_next = ST_L_UP;
                    end
                    else if (cmd && frame_ready_reg)
                    begin
                        state_next = ST_E_A22;
                    end
                end
            end
            ST_L_UP:    state_next = ST_L_WR;
            ST_L_WR:    state_next = ST_IDLE;
            ST_E_A22:   state_next = ST_E_A21;
            ST_E_A21:   state_next = ST_E_A12;
            ST_E_A12:   state_next = ST_E_A11;
            ST_E_A11:   state_next = ST_E_PIX;
            ST_E_PIX:   state_next = ST_E_AREA;
            ST_E_AREA:  state_next = ST_E_PROD;
            ST_E_PROD:  state_next = ST_E_SCALE;
            ST_E_SCALE: state_next = ST_E_CMP;
            ST_E_CMP:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            width_reg       <= CFG_DIM_RESET;
            height_reg      <= CFG_DIM_RESET;
            load_x_reg      <= '0;
            load_y_reg      <= '0;
            emit_x_reg      <= '0;
            emit_y_reg      <= '0;
            rowsum_reg      <= '0;
            frame_ready_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (cfg_wr)
            begin
                // Any register write restarts the frame
                if (paddr[2] == REG_FRAME_WIDTH)
                begin
                    width_reg <= pwdata[CFG_W-1:0];
                end
                else
                begin
                    height_reg <= pwdata[CFG_W-1:0];
                end
                load_x_reg      <= '0;
                load_y_reg      <= '0;
                emit_x_reg      <= '0;
                emit_y_reg      <= '0;
                rowsum_reg      <= '0;
                frame_ready_reg <= 1'b0;
            end
            else
            begin
                if (accept && !cmd && !frame_ready_reg)
                begin
                    rowsum_reg <= ((load_x_reg == '0) ? '0 : rowsum_reg)
                                  + ROWSUM_W'(gray_pixel);
                end

                if (accept && cmd && !frame_ready_reg)
                begin
                    done_reg <= 1'b1;
                end

                if (state_reg == ST_L_WR)
                begin
                    if (load_col_end)
                    begin
                        load_x_reg <= '0;
                        if (load_row_end)
                        begin
                            load_y_reg      <= '0;
                            frame_ready_reg <= 1'b1;
                        end
                        else
                        begin
                            load_y_reg <= load_y_reg + CRD_W'(1);
                        end
                    end
                    else
                    begin
                        load_x_reg <= load_x_reg + CRD_W'(1);
                    end
                end

                if (state_reg == ST_E_CMP)
                begin
                    done_reg <= 1'b1;
                    if (emit_col_end && emit_row_end)
                    begin
                        // Final pixel: start a new frame
                        emit_x_reg      <= '0;
                        emit_y_reg      <= '0;
                        load_x_reg      <= '0;
                        load_y_reg      <= '0;
                        rowsum_reg      <= '0;
                        frame_ready_reg <= 1'b0;
                    end
                    else if (emit_col_end)
                    begin
                        emit_x_reg <= '0;
                        emit_y_reg <= emit_y_reg + CRD_W'(1);
                    end
                    else
                    begin
                        emit_x_reg <= emit_x_reg + CRD_W'(1);
                    end
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= gray_pixel;
            x1_reg  <= x1_next;
            x2_reg  <= x2_next;
            y1_reg  <= y1_next;
            y2_reg  <= y2_next;
        end

        case (state_reg)
            ST_E_A12:   acc_reg <= integ_rd;
            ST_E_A11:   acc_reg <= acc_reg - integ_rd;
            ST_E_PIX:   acc_reg <= acc_reg - integ_rd;
            ST_E_AREA:  acc_reg <= acc_reg + integ_rd;
            default:    acc_reg <= acc_reg;
        endcase

        // 10 * pixel * area against 7 * window sum
        if (state_reg == ST_E_SCALE)
        begin
            lhs_reg <= (LHS_W'(mul_q) << 3) + (LHS_W'(mul_q) << 1);
            rhs_reg <= (RHS_W'(acc_reg) << 3) - RHS_W'(acc_reg);
        end

        if (accept && cmd && !frame_ready_reg)
        begin
            binary_reg <= PIX_DARK;
            status_reg <= STATUS_NOT_READY;
            last_reg   <= 1'b0;
        end
        else if (state_reg == ST_E_CMP)
        begin
            binary_reg <= (CMP_W'(lhs_reg) < CMP_W'(rhs_reg)) ? PIX_DARK : PIX_LIGHT;
            status_reg <= STATUS_OK;
            last_reg   <= emit_col_end && emit_row_end;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_WIDTH)
        begin
            prdata = APB_DW'(width_reg);
        end
        else
        begin
            prdata = APB_DW'(height_reg);
        end
    end

    assign pready     = 1'b1;
    assign done       = done_reg;
    assign binary_out = binary_reg;
    assign status     = status_reg;
    assign last_pixel = last_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for bradley_adaptive_threshold_unit: loads gray frames,
// emits results, and checks each one against an in-bench integral-image predictor.
// Depends on rtl/bat_pkg.sv and rtl/bradley_adaptive_threshold_unit.sv.
`timescale 1ns / 1ps

module tb;
    import bat_pkg::*;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_EMIT      = 1'b1;
    localparam int   STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   CYCLE_LIMIT   = 800000;
    localparam int   RANDOM_ITEMS  = 1900;
    localparam int   PRINT_CAP     = 40;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] gray;
    } pix_cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             stat;
        logic             is_last;
    } thr_result_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic               cmd        = 1'b0;
    logic [PIX_W-1:0]   gray_pixel = '0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [APB_DW-1:0]  pwdata     = '0;
    wire                busy;
    wire                done;
    wire  [PIX_W-1:0]   binary_out;
    wire                status;
    wire                last_pixel;
    wire  [APB_DW-1:0]  prdata;
    wire                pready;

    // Predictor state: stored frame, integral image, positions and registers
    logic [PIX_W-1:0]    pix_mem   [STORE_DEPTH];
    logic [INTEG_W-1:0]  integ_mem [STORE_DEPTH];
    logic [ROWSUM_W-1:0] row_sum      = '0;
    int unsigned         load_pos     = 0;
    int unsigned         emit_pos     = 0;
    bit                  frame_loaded = 1'b0;
    logic [CFG_W-1:0]    width_reg    = CFG_DIM_RESET;
    logic [CFG_W-1:0]    height_reg   = CFG_DIM_RESET;

    pix_cmd_t    pix_cmds_q[$];
    thr_result_t thr_results_q[$];
    int          idle_pct    = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int unsigned rand_items  = 0;

    bradley_adaptive_threshold_unit u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void restart_frame();
        row_sum      = '0;
        load_pos     = 0;
        emit_pos     = 0;
        frame_loaded = 1'b0;
    endfunction

    // Advance the predictor by one accepted item; queue the result it causes
    function automatic void threshold_item(input logic c, input logic [PIX_W-1:0] g);
        int unsigned       w, h, total, x, y, half, xa, xb, ya, yb;
        logic [INTEG_W-1:0] above, wsum;
        longint unsigned   area, pix_l, wsum_l;
        thr_result_t       r;
        w     = eff_dim(width_reg, DEF_MAX_WIDTH);
        h     = eff_dim(height_reg, DEF_MAX_HEIGHT);
        total = w * h;
        if (c == CMD_LOAD) begin
            if (frame_loaded)
                return;
            x = load_pos % w;
            y = load_pos / w;
            if (x == 0)
                row_sum = '0;
            row_sum = row_sum + g;
            above = (y > 0) ? integ_mem[(y - 1) * w + x] : '0;
            pix_mem[load_pos]   = g;
            integ_mem[load_pos] = above + row_sum;
            if (load_pos + 1 >= total) begin
                frame_loaded = 1'b1;
                load_pos     = 0;
            end
            else begin
                load_pos = load_pos + 1;
            end
            return;
        end
        if (!frame_loaded) begin
            r.level   = PIX_DARK;
            r.stat    = STATUS_NOT_READY;
            r.is_last = 1'b0;
            thr_results_q.push_back(r);
            return;
        end
        x    = emit_pos % w;
        y    = emit_pos / w;
        half = w >> HALF_SHIFT;
        xa   = (x >= half) ? x - half : 0;
        xb   = (x + half > w - 1) ? w - 1 : x + half;
        ya   = (y >= half) ? y - half : 0;
        yb   = (y + half > h - 1) ? h - 1 : y + half;
        area = xb - xa;
        area = area * (yb - ya);
        wsum = integ_mem[yb * w + xb] - integ_mem[ya * w + xb]
             - integ_mem[yb * w + xa] + integ_mem[ya * w + xa];
        wsum_l = wsum;
        pix_l  = pix_mem[emit_pos];
        r.level   = (10 * pix_l * area < 7 * wsum_l) ? PIX_DARK : PIX_LIGHT;
        r.stat    = STATUS_OK;
        r.is_last = (emit_pos + 1 >= total);
        thr_results_q.push_back(r);
        if (r.is_last)
            restart_frame();
        else
            emit_pos = emit_pos + 1;
    endfunction

    function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                        input logic [PIX_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
                $display("%0t %s: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Driver: hold an item until accepted, then offer the next or idle
    always @(posedge clk)
    begin
        pix_cmd_t next_it;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy)
                threshold_item(cmd, gray_pixel);
            if (!start || !busy) begin
                if (pix_cmds_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_it    = pix_cmds_q.pop_front();
                    start      <= 1'b1;
                    cmd        <= next_it.cmd;
                    gray_pixel <= next_it.gray;
                end
                else begin
                    start      <= 1'b0;
                    cmd        <= $urandom_range(1);
                    gray_pixel <= $urandom_range(255);
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation
    always @(posedge clk)
    begin
        thr_result_t want;
        if (rst_n && done) begin
            if (thr_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display("%0t unexpected result: expected none actual %0d/%0d/%0d",
                             $time, binary_out, status, last_pixel);
            end
            else begin
                want = thr_results_q.pop_front();
                check_field("binary_out", want.level, binary_out);
                check_field("status", {7'b0, want.stat}, {7'b0, status});
                check_field("last_pixel", {7'b0, want.is_last}, {7'b0, last_pixel});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic add_item(input logic c, input logic [PIX_W-1:0] g);
        pix_cmd_t it;
        it.cmd  = c;
        it.gray = g;
        pix_cmds_q.push_back(it);
    endtask

    // Wait until every item is taken and every result is back, then let loads finish
    task automatic settle();
        @(posedge clk);
        while (!(pix_cmds_q.size() == 0 && !start && !busy && thr_results_q.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom << CFG_W) | val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        restart_frame();
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Queue one frame of loads then its emits; a broken frame stops loading early
    task automatic queue_frame(input int unsigned w, input int unsigned h, input bit broken);
        int unsigned      total, n_loads, mode, i;
        logic [PIX_W-1:0] g, base;
        total   = w * h;
        n_loads = broken ? $urandom_range(total - 1, 0) : total;
        mode    = $urandom_range(2);
        base    = $urandom_range(255);
        for (i = 0; i < n_loads; i++) begin
            case (mode)
                0: g = $urandom_range(255);
                1:
                begin
                    g = ((i % w) * 255) / w;
                    g = g ^ $urandom_range(15);
                end
                default: g = ($urandom_range(9) != 0) ? base :
                             ($urandom_range(1) ? PIX_LIGHT : PIX_DARK);
            endcase
            // an emit before the frame is complete yields a void result
            if ($urandom_range(24) == 0) begin
                add_item(CMD_EMIT, $urandom_range(255));
                rand_items++;
            end
            add_item(CMD_LOAD, g);
        end
        rand_items += n_loads;
        if (broken) begin
            repeat ($urandom_range(3, 1)) begin
                add_item(CMD_EMIT, $urandom_range(255));
                rand_items++;
            end
            return;
        end
        // drop: loads after the frame is complete are ignored
        repeat ($urandom_range(2)) add_item(CMD_LOAD, $urandom_range(255));
        for (i = 0; i < total; i++) begin
            if ($urandom_range(29) == 0)
                add_item(CMD_LOAD, $urandom_range(255));
            add_item(CMD_EMIT, $urandom_range(255));
        end
        rand_items += total;
    endtask

    initial
    begin
        int unsigned      phase, n_frames;
        logic [CFG_W-1:0] w_raw, h_raw;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: emit with nothing loaded, a tiny frame, ignored loads, new frame
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_LOAD, 8'hFF);
        settle();
        set_frame(9'd2, 9'd2);
        add_item(CMD_LOAD, 8'h00);
        add_item(CMD_EMIT, 8'hFF);
        add_item(CMD_LOAD, 8'hFF);
        add_item(CMD_LOAD, 8'h80);
        add_item(CMD_LOAD, 8'h01);
        add_item(CMD_LOAD, 8'h5A);
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_LOAD, 8'hA5);
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_EMIT, 8'h00);
        add_item(CMD_LOAD, 8'h7F);
        settle();

        // Register extremes, including out-of-range values that clamp
        idle_pct = 58;
        set_frame(9'd256, 9'd1);
        queue_frame(256, 1, 1'b0);
        settle();
        idle_pct = 6;
        set_frame(9'd1, 9'd256);
        queue_frame(1, 256, 1'b0);
        settle();
        idle_pct = 0;
        set_frame(9'd511, 9'd0);
        queue_frame(256, 1, 1'b0);
        settle();

        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 58;
                default: idle_pct = 6;
            endcase
            case ($urandom_range(9))
                6:
                begin
                    w_raw = $urandom_range(15);
                    h_raw = $urandom_range(8);
                end
                7:
                begin
                    w_raw = $urandom_range(64, 41);
                    h_raw = $urandom_range(3, 1);
                end
                8, 9:
                begin
                    w_raw = $urandom_range(24, 16);
                    h_raw = $urandom_range(12, 6);
                end
                default:
                begin
                    w_raw = $urandom_range(40, 16);
                    h_raw = $urandom_range(5, 1);
                end
            endcase
            set_frame(w_raw, h_raw);
            n_frames = $urandom_range(2, 1);
            repeat (n_frames)
                queue_frame(eff_dim(w_raw, DEF_MAX_WIDTH), eff_dim(h_raw, DEF_MAX_HEIGHT),
                            $urandom_range(7) == 0);
            settle();
            phase++;
        end

        settle();
        if (fail_count == 0 && thr_results_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bat_pkg.sv
rtl/bat_muladd.sv
rtl/bat_store.sv
rtl/bradley_adaptive_threshold_unit.sv
tb/tb.sv
